/* rtl/core/kvts_pkg.sv */
// Package for the keyframe vector track sampler.
// Holds status codes, command codes and shared structs; no dependencies.
`timescale 1ns / 1ps
package kvts_pkg;

    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int STATUS_W = 3;

    typedef enum logic
    {
        CMD_APPEND = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_INTERP   = 3'd0,
        ST_HELD     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_STORED   = 3'd3,
        ST_FULL     = 3'd4,
        ST_ZERO_SEG = 3'd5
    } status_t;

    // Divider control between sequencer and divider
    typedef struct packed
    {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

endpackage

/* rtl/core/kvts_stream_if.sv */
// Valid/ready stream interface carrying one payload type.
// Depends on nothing but the payload width parameter.
`timescale 1ns / 1ps
interface kvts_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/kvts_divider.sv */
// Restoring divider, one quotient bit per cycle.
// Uses kvts_pkg for the control struct.
`timescale 1ns / 1ps
module kvts_divider
    import kvts_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output div_ctrl_t        ctrl,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    // Shift in one numerator bit and compare
    always_comb
    begin
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
            den_reg <= denom;
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
    assign quot       = quot_reg;
endmodule

/* rtl/core/kvts_key_table.sv */
// Key table: one synchronous memory of time and x, y, z per entry.
// Uses kvts_pkg for field widths; one write and one registered read port.
`timescale 1ns / 1ps
module kvts_key_table
    import kvts_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [TIME_W+3*VALUE_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [TIME_W+3*VALUE_W-1:0] rd_data
);
    logic [TIME_W+3*VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/core/keyframe_vector_track_sampler.sv */
// Top level of the keyframe vector track sampler.
// Depends on kvts_pkg, kvts_stream_if, kvts_key_table and kvts_divider.
`timescale 1ns / 1ps
// Usage
//   in_ch  : command, time_value, key_x, key_y, key_z (valid/ready).
//   out_ch : out_x, out_y, out_z, segment_index, status (valid/ready).
//   One transaction at a time. An append, a sample of an empty table and
//   a sample of a single key go from acceptance through S_OUT to the
//   output register. A sample scans the key table through its single
//   registered read port, one key at a time (address, then compare),
//   up to the upper key of the segment, then reads its lower key; a
//   zero-length segment then goes straight to S_OUT. An interpolation
//   adds the bit-serial divider and three multiplies done in sequence
//   on one multiplier, and the result then goes through S_OUT to the
//   output register. A time past the last key scans every key and holds
//   the last one.
//   Reset empties the table (count to zero); the memory is not cleared,
//   only entries below the count are ever used.
//   If the receiver stalls the result sits in the output register and
//   no new transaction is taken until it has gone.
module keyframe_vector_track_sampler
    import kvts_pkg::*;
#(
    parameter int TABLE_DEPTH   = 64,
    parameter int FRACTION_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    kvts_stream_if.sink   in_ch,
    kvts_stream_if.source out_ch
);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_W = TIME_W + FRACTION_BITS;
    localparam int ENT_W = TIME_W + 3*VALUE_W;
    localparam int PROD_W = VALUE_W + 1 + FRACTION_BITS + 2;

    typedef enum logic [8:0]
    {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_LOWR  = 9'b000001000,
        S_LOWD  = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_ACC   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;      // key being read
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] t1_reg;       // upper key time
    logic [3*VALUE_W-1:0] v1_reg;    // upper key values
    logic [3*VALUE_W-1:0] v0_reg;
    logic [FRACTION_BITS:0] frac_reg;
    logic [1:0]        comp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [3*VALUE_W-1:0] res_reg;
    logic [INDEX_W-1:0] seg_out_reg;
    status_t           st_reg;
    logic              ovalid_reg;
    logic [AW-1:0]     seg_reg;

    logic              wr_en;
    logic [AW-1:0]     rd_addr;
    logic [ENT_W-1:0]  rd_data;
    logic              div_start;
    div_ctrl_t         div_ctrl;
    logic [NUM_W-1:0]  quot;
    logic [TIME_W-1:0] den, num;

    logic in_fire;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign wr_en       = in_fire && (in_ch.data[0] == CMD_APPEND)
                         && (count_reg < CW'(TABLE_DEPTH));

    kvts_key_table #(.DEPTH(TABLE_DEPTH)) u_table
    (
        .clk(clk), .wr_en(wr_en), .wr_addr(count_reg[AW-1:0]),
        .wr_data(in_ch.data[ENT_W:1]), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // data layout: {z, y, x, time, command}
    wire [TIME_W-1:0]    rd_time = rd_data[TIME_W-1:0];
    wire [3*VALUE_W-1:0] rd_vals = rd_data[ENT_W-1:TIME_W];

    assign den = (t1_reg >= rd_time) ? t1_reg - rd_time : rd_time - t1_reg;
    assign num = (t_reg >= rd_time) ? t_reg - rd_time : rd_time - t_reg;
    assign div_start = (state_reg == S_LOWD) && (den != '0);

    kvts_divider #(.NUM_W(NUM_W), .DEN_W(TIME_W)) u_div
    (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .numer({num, FRACTION_BITS'(0)}), .denom(den),
        .ctrl(div_ctrl), .quot(quot)
    );

    // Read address: key 0 while idle (single-key hold), then the scan
    // counter or the chosen lower key
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (state_reg == S_IDLE)
            rd_addr = '0;
        else if (state_reg == S_LOWR)
            rd_addr = seg_reg;
    end

    // Component mux for the multiplier
    logic signed [VALUE_W-1:0] a0, a1;
    logic signed [VALUE_W:0]   diff;
    always_comb
    begin
        case (comp_reg)
            2'd0:    begin a0 = v0_reg[VALUE_W-1:0];           a1 = v1_reg[VALUE_W-1:0]; end
            2'd1:    begin a0 = v0_reg[2*VALUE_W-1:VALUE_W];   a1 = v1_reg[2*VALUE_W-1:VALUE_W]; end
            default: begin a0 = v0_reg[3*VALUE_W-1:2*VALUE_W]; a1 = v1_reg[3*VALUE_W-1:2*VALUE_W]; end
        endcase
        diff = {a1[VALUE_W-1], a1} - {a0[VALUE_W-1], a0};
    end
    wire signed [PROD_W-1:0] prod_w =
        PROD_W'(diff) * $signed({1'b0, frac_reg});
    wire [VALUE_W-1:0] sum_w = a0 + VALUE_W'(prod_reg >>> FRACTION_BITS);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire && in_ch.data[0] == CMD_SAMPLE && count_reg > CW'(1))
                    state_next = S_SCAN;
                else if (in_fire)
                    state_next = S_OUT;
            S_SCAN: state_next = S_WAIT;
            S_WAIT:
                if (t_reg < rd_time)
                    state_next = S_LOWR;
                else if (idx_reg + 1'b1 >= count_reg)
                    state_next = S_OUT;
                else
                    state_next = S_SCAN;
            S_LOWR: state_next = S_LOWD;
            S_LOWD: state_next = (den == '0) ? S_OUT : S_DIV;
            S_DIV:  state_next = div_ctrl.done ? S_MUL : S_DIV;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (comp_reg == 2'd2) ? S_OUT : S_MUL;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
                count_reg <= count_reg + 1'b1;
            if (state_reg == S_OUT)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    t_reg   <= in_ch.data[TIME_W:1];
                    idx_reg <= CW'(1);
                    res_reg <= '0;
                    seg_out_reg <= '0;
                    if (in_ch.data[0] == CMD_APPEND)
                    begin
                        if (wr_en)
                        begin
                            st_reg      <= ST_STORED;
                            seg_out_reg <= INDEX_W'(count_reg);
                        end
                        else
                            st_reg <= ST_FULL;
                    end
                    else if (count_reg == '0)
                        st_reg <= ST_EMPTY;
                    else
                        st_reg <= ST_HELD;
                end
            S_SCAN: ;
            S_WAIT:
            begin
                t1_reg <= rd_time;
                v1_reg <= rd_vals;
                seg_reg <= AW'(idx_reg - 1'b1);
                if (!(t_reg < rd_time))
                begin
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        res_reg     <= rd_vals;
                        seg_out_reg <= INDEX_W'(idx_reg);
                        st_reg      <= ST_HELD;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_LOWR: ;
            S_LOWD:
            begin
                v0_reg      <= rd_vals;
                res_reg     <= rd_vals;
                seg_out_reg <= INDEX_W'(seg_reg);
                st_reg      <= (den == '0) ? ST_ZERO_SEG : ST_INTERP;
                comp_reg    <= 2'd0;
            end
            S_DIV:
                if (div_ctrl.done)
                    frac_reg <= (quot > NUM_W'(1 << FRACTION_BITS))
                        ? (FRACTION_BITS+1)'(1 << FRACTION_BITS)
                        : quot[FRACTION_BITS:0];
            S_MUL:  prod_reg <= prod_w;
            S_ACC:
            begin
                case (comp_reg)
                    2'd0:    res_reg[VALUE_W-1:0]           <= sum_w;
                    2'd1:    res_reg[2*VALUE_W-1:VALUE_W]   <= sum_w;
                    default: res_reg[3*VALUE_W-1:2*VALUE_W] <= sum_w;
                endcase
                comp_reg <= comp_reg + 1'b1;
            end
            S_OUT:
                if (st_reg == ST_HELD && count_reg == CW'(1))
                    res_reg <= rd_vals;
            default: ;
        endcase
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = {st_reg, seg_out_reg, res_reg};

    // Assertions
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("key count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
        else $error("result changed under stall");
endmodule
